// ===== src/s256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 byte-stream hasher.
`default_nettype none

package s256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    localparam logic [7:0] PadMark  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    localparam logic [31:0] K_TAB [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_COMP = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_PAD  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        BS_DATA = 2'd0,
        BS_MARK = 2'd1,
        BS_ZERO = 2'd2,
        BS_LEN  = 2'd3
    } t_bsel;

    typedef struct packed {
        logic        shift;
        t_bsel       bsel;
        logic [2:0]  len_idx;
        logic        add_bits;
        logic        clr_bits;
        logic        start;
        logic        round;
        logic [5:0]  rnd;
        logic        fin;
        logic        load_iv;
        logic [2:0]  out_idx;
    } t_cmd;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ===== src/sha256_byte_stream_hasher_unit.sv =====
// Top level of the SHA-256 byte-stream hasher: controller, datapath and checks.
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_in_valid / o_in_ready   | i_data_byte, i_has_byte, i_end_of_message
//  output  | out       | o_out_valid / i_out_ready | o_digest_word, o_word_index, o_last_word
//
// An item that neither completes a 64-byte block nor ends the message leaves the block idle.
// A byte that completes a block holds off input while the block is compressed: one round a
// cycle through the single round unit, then a fold of the result into the chaining value.
// An end-of-message item starts padding with a mark byte, zero bytes and the 64-bit length,
// adding a second padded block when more than 55 bytes are pending; then eight digest words.
// Reset is synchronous and restores the initial chaining value; no clearing pass.
// Input is taken only while idle; a stalled output holds its word until taken.
`default_nettype none

module sha256_byte_stream_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import s256_pkg::*;

    t_cmd cmd;

    s256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .o_cmd            (cmd)
    );

    s256_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .o_word      (o_digest_word)
    );

    // Input is never taken while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest words are pending");

    // Digest words follow one another in index order with no gap.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word) |=>
        (o_out_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest word sequence broken");

    // Once the last word is taken the block is ready for the next message.
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word) |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after the final digest word");

endmodule

`default_nettype wire

// ===== src/s256_ctrl.sv =====
// Controller state machine: byte collection, padding sequence, rounds and digest output.
`default_nettype none

module s256_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_has_byte,
    input  wire logic          i_end_of_message,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [2:0]         o_word_index,
    output logic               o_last_word,
    output s256_pkg::t_cmd     o_cmd
);
    import s256_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_oidx, n_oidx;
    logic       r_pend, n_pend;
    logic       r_mark, n_mark;
    logic       r_len, n_len;
    logic       in_acc;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_OUT);
    assign o_word_index = r_oidx;
    assign o_last_word  = (r_oidx == 3'd7);
    assign in_acc       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_oidx  = r_oidx;
        n_pend  = r_pend;
        n_mark  = r_mark;
        n_len   = r_len;

        o_cmd          = '0;
        o_cmd.bsel     = BS_DATA;
        o_cmd.len_idx  = r_fill[2:0];
        o_cmd.rnd      = r_rnd;
        o_cmd.out_idx  = r_oidx;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pend = i_end_of_message;
                    if (i_has_byte) begin
                        o_cmd.shift    = 1'b1;
                        o_cmd.add_bits = 1'b1;
                        n_fill         = r_fill + 6'd1;
                    end
                    // A byte that completes the block is compressed before any padding.
                    if (i_has_byte && (r_fill == 6'd63)) begin
                        o_cmd.start = 1'b1;
                        n_rnd       = '0;
                        n_state     = ST_COMP;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.shift = 1'b1;
                if (!r_mark) begin
                    o_cmd.bsel = BS_MARK;
                    n_mark     = 1'b1;
                end else if (r_len || (r_fill == LenStart)) begin
                    o_cmd.bsel = BS_LEN;
                    n_len      = 1'b1;
                end else begin
                    o_cmd.bsel = BS_ZERO;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    o_cmd.start = 1'b1;
                    n_rnd       = '0;
                    n_state     = ST_COMP;
                end
            end
            ST_COMP: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                if (r_len) begin
                    n_state = ST_OUT;
                end else if (r_pend) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_oidx == 3'd7) begin
                        o_cmd.load_iv  = 1'b1;
                        o_cmd.clr_bits = 1'b1;
                        n_oidx         = '0;
                        n_pend         = 1'b0;
                        n_mark         = 1'b0;
                        n_len          = 1'b0;
                        n_state        = ST_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_pend  <= 1'b0;
            r_mark  <= 1'b0;
            r_len   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_pend  <= n_pend;
            r_mark  <= n_mark;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ===== src/s256_dp.sv =====
// Datapath: block shift register with message schedule, round registers and chaining value.
`default_nettype none

module s256_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire s256_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_data_byte,
    output logic [31:0]        o_word
);
    import s256_pkg::*;

    logic [511:0] r_blk;
    logic [31:0]  r_v  [8];
    logic [31:0]  r_hv [8];
    logic [63:0]  r_bits;

    logic [7:0]   fill_byte;
    logic [63:0]  len_shift;
    logic [31:0]  w0, w1, w9, w14, w_new;
    logic [31:0]  t1, t2, ch, maj;

    // Length bytes go out most significant first; the byte index counts from there.
    assign len_shift = r_bits >> {~i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.bsel)
            BS_DATA: fill_byte = i_data_byte;
            BS_MARK: fill_byte = PadMark;
            BS_ZERO: fill_byte = 8'h00;
            BS_LEN:  fill_byte = len_shift[7:0];
            default: fill_byte = 8'h00;
        endcase
    end

    // The window's oldest word sits at the top; each round retires it and appends a new one.
    assign w0    = r_blk[511:480];
    assign w1    = r_blk[479:448];
    assign w9    = r_blk[223:192];
    assign w14   = r_blk[63:32];
    assign w_new = w0 + sml_sig0(w1) + w9 + sml_sig1(w14);

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sig1(r_v[4]) + ch + K_TAB[i_cmd.rnd] + w0;
    assign t2  = big_sig0(r_v[0]) + maj;

    assign o_word = r_hv[i_cmd.out_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_blk <= {r_blk[503:0], fill_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v <= r_hv;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= IV_TAB;
            r_bits <= '0;
        end else begin
            if (i_cmd.load_iv) begin
                r_hv <= IV_TAB;
            end else if (i_cmd.fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_hv[i] <= r_hv[i] + r_v[i];
                end
            end
            if (i_cmd.clr_bits) begin
                r_bits <= '0;
            end else if (i_cmd.add_bits) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

endmodule

`default_nettype wire
